// File: hw/rtl/slba_pkg.sv
`default_nettype none
package slba_pkg;

  localparam int MIN_SHIFT = 4;
  localparam int MAX_SHIFT = 11;
  localparam int CLASS_N   = MAX_SHIFT - MIN_SHIFT + 1;
  localparam int SLABS     = 16;
  localparam int CLS_W     = 3;
  localparam int SLAB_W    = 4;
  localparam int OBJ_IDX_W = 8;
  localparam int SLAB_ID_W = CLS_W + SLAB_W;
  localparam int OBJ_W     = 166;
  localparam int CNT_W     = 8;
  localparam int ROW_W     = 2 * SLABS;
  localparam int USE_W     = 13;
  localparam int SIZE_W    = 16;
  localparam int NEED_W    = SIZE_W + 1;
  localparam int CHUNK_W   = 32;
  localparam int CHUNK_N   = (OBJ_W + CHUNK_W - 1) / CHUNK_W;

  // result codes
  localparam logic [2:0] RES_ALLOC     = 3'd0;
  localparam logic [2:0] RES_ZERO      = 3'd1;
  localparam logic [2:0] RES_TOO_LARGE = 3'd2;
  localparam logic [2:0] RES_NO_SLAB   = 3'd3;
  localparam logic [2:0] RES_FREED     = 3'd4;
  localparam logic [2:0] RES_BAD_FREE  = 3'd5;

  // slab states
  localparam logic [1:0] SS_NONE    = 2'd0;
  localparam logic [1:0] SS_FREE    = 2'd1;
  localparam logic [1:0] SS_PARTIAL = 2'd2;
  localparam logic [1:0] SS_FULL    = 2'd3;

  typedef struct packed {
    logic                 en;
    logic [CLS_W-1:0]     addr;
    logic [ROW_W-1:0]     row;
  } row_wr_t;

  typedef struct packed {
    logic                 en;
    logic [SLAB_ID_W-1:0] addr;
    logic [OBJ_W-1:0]     bitmap;
    logic [CNT_W-1:0]     count;
  } slab_wr_t;

  // objects per page for each class, header and aligned bitmap included
  function automatic logic [CNT_W-1:0] class_capacity(input logic [CLS_W-1:0] cls);
    logic [CNT_W-1:0] n;
    unique case (cls)
      3'd0: n = 8'd166;
      3'd1: n = 8'd100;
      3'd2: n = 8'd55;
      3'd3: n = 8'd29;
      3'd4: n = 8'd15;
      3'd5: n = 8'd7;
      3'd6: n = 8'd3;
      3'd7: n = 8'd1;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/slab_bitmap_allocator_top.sv
// Slab allocator with eight power-of-two size classes (16 to 2048 bytes,
// each holding the request plus an 8-byte back pointer) and 16 slab slots
// per class. A request is a beat on in_: in_tuser says allocate or free. Every
// request gives one result beat on out_ with a status code and, for an
// allocate, the handle and usable size. A request passes through accept, read
// of the class status row, read of the slab bitmap and use count, then update
// and write-back, which waits while the output is full and out_tready is low;
// a new request is taken only once the result sits in the output register.
// This order is set by the dependent reads: the slab to use is known only
// after the status row returns, and only then can the bitmap memory be read.
// No clearing pass runs after reset; the block is ready at once.
`default_nettype none
module slab_bitmap_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] request_size, [18:16] handle_class, [22:19] handle_slab,
  // [30:23] handle_object, [31] zero
  input  wire logic [31:0] in_tdata,
  // [0] operation
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] status, [5:3] result_class, [9:6] result_slab,
  // [17:10] result_object, [30:18] usable_bytes, [31] zero
  output logic [31:0]      out_tdata
);

  localparam int CLS_W  = slba_pkg::CLS_W;
  localparam int SLAB_W = slba_pkg::SLAB_W;
  localparam int OBJ_W  = slba_pkg::OBJ_W;
  localparam int CNT_W  = slba_pkg::CNT_W;
  localparam int ROW_W  = slba_pkg::ROW_W;
  localparam int IDX_W  = slba_pkg::OBJ_IDX_W;
  localparam int NEED_W = slba_pkg::NEED_W;

  typedef enum logic [1:0] {S_IDLE, S_ROW, S_MEM, S_FIN} state_t;

  state_t state_r;

  logic in_fire, fin_fire;
  logic op_in;
  logic [slba_pkg::SIZE_W-1:0] size_in;
  logic [CLS_W-1:0]  hc_in;
  logic [SLAB_W-1:0] hs_in;
  logic [IDX_W-1:0]  ho_in;
  logic [NEED_W-1:0] need;
  logic [CLS_W-1:0]  size_cls;
  logic              too_big;

  logic op_r, zero_r, big_r;
  logic [CLS_W-1:0]  cls_r;
  logic [SLAB_W-1:0] hs_r, pick_r;
  logic [IDX_W-1:0]  ho_r;
  logic [1:0]        pick_st_r;
  logic              found_r;
  logic [ROW_W-1:0]  row_r;
  logic [OBJ_W-1:0]  bm_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [CLS_W-1:0]  row_raddr;
  logic [ROW_W-1:0]  row_rd;
  logic [slba_pkg::SLAB_ID_W-1:0] slab_raddr;
  logic [OBJ_W-1:0]  bm_rd, bm_eff;
  logic [CNT_W-1:0]  cnt_rd;
  logic [SLAB_W-1:0] pick_nxt;
  logic [1:0]        pick_st_nxt;
  logic              found_nxt;

  logic              scan_found;
  logic [IDX_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  obj_n;

  slba_pkg::row_wr_t  row_wr;
  slba_pkg::slab_wr_t slab_wr;

  logic [2:0]        res_status;
  logic [CLS_W-1:0]  res_class;
  logic [SLAB_W-1:0] res_slab;
  logic [IDX_W-1:0]  res_obj;
  logic [slba_pkg::USE_W-1:0] res_usable;
  logic              out_valid_r;
  logic [31:0]       out_data_r;

  assign op_in   = in_tuser[0];
  assign size_in = in_tdata[15:0];
  assign hc_in   = in_tdata[18:16];
  assign hs_in   = in_tdata[22:19];
  assign ho_in   = in_tdata[30:23];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign fin_fire  = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // smallest class whose size holds the request plus back pointer
  always_comb begin
    need     = NEED_W'(size_in) + NEED_W'(8);
    size_cls = '0;
    too_big  = need > (NEED_W'(1) << slba_pkg::MAX_SHIFT);
    for (int s = slba_pkg::MAX_SHIFT; s >= slba_pkg::MIN_SHIFT; s--) begin
      if ((NEED_W'(1) << s) >= need) begin
        size_cls = CLS_W'(s - slba_pkg::MIN_SHIFT);
      end
    end
  end

  assign row_raddr = op_in ? hc_in : size_cls;

  slba_status_mem u_status (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (row_raddr),
    .rd_row  (row_rd),
    .wr      (row_wr)
  );

  // allocate: partial first, then free, then an uncreated slot; lowest index wins; a free takes the handle's slab
  always_comb begin
    found_nxt   = 1'b0;
    pick_nxt    = '0;
    pick_st_nxt = slba_pkg::SS_NONE;
    for (int k = slba_pkg::SLABS - 1; k >= 0; k--) begin
      if (row_rd[2*k +: 2] == slba_pkg::SS_NONE) begin
        found_nxt = 1'b1;
        pick_nxt  = SLAB_W'(k);
      end
    end
    for (int k = slba_pkg::SLABS - 1; k >= 0; k--) begin
      if (row_rd[2*k +: 2] == slba_pkg::SS_FREE) begin
        pick_nxt = SLAB_W'(k);
      end
    end
    for (int k = slba_pkg::SLABS - 1; k >= 0; k--) begin
      if (row_rd[2*k +: 2] == slba_pkg::SS_PARTIAL) begin
        pick_nxt = SLAB_W'(k);
      end
    end
    for (int k = 0; k < slba_pkg::SLABS; k++) begin
      if (row_rd[2*k +: 2] == slba_pkg::SS_FREE ||
          row_rd[2*k +: 2] == slba_pkg::SS_PARTIAL) begin
        found_nxt = 1'b1;
      end
    end
    if (op_r) begin
      pick_nxt  = hs_r;
      found_nxt = 1'b1;
    end
    pick_st_nxt = row_rd[2*pick_nxt +: 2];
  end

  assign slab_raddr = {cls_r, pick_nxt};

  slba_slab_mem u_slab (
    .clk       (clk),
    .rd_addr   (slab_raddr),
    .rd_bitmap (bm_rd),
    .rd_count  (cnt_rd),
    .wr        (slab_wr)
  );

  // an uncreated slab starts empty whatever the memory holds
  assign bm_eff = (pick_st_r == slba_pkg::SS_NONE) ? '0 : bm_rd;
  assign obj_n  = slba_pkg::class_capacity(cls_r);

  slba_zero_scan u_scan (
    .clk    (clk),
    .en     (state_r == S_MEM),
    .bitmap (bm_eff),
    .obj_n  (obj_n),
    .found  (scan_found),
    .index  (scan_idx)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= op_in;
      zero_r <= (size_in == '0);
      big_r  <= too_big;
      cls_r  <= row_raddr;
      hs_r   <= hs_in;
      ho_r   <= ho_in;
    end
    if (state_r == S_ROW) begin
      row_r     <= row_rd;
      pick_r    <= pick_nxt;
      pick_st_r <= pick_st_nxt;
      found_r   <= found_nxt;
    end
    if (state_r == S_MEM) begin
      bm_r  <= bm_eff;
      cnt_r <= (pick_st_r == slba_pkg::SS_NONE) ? '0 : cnt_rd;
    end
  end

  always_comb begin
    logic [CNT_W-1:0] cnt_new;
    logic [1:0]       st_new;
    logic [OBJ_W-1:0] one_hot;
    res_status = slba_pkg::RES_BAD_FREE;
    res_class  = '0;
    res_slab   = '0;
    res_obj    = '0;
    res_usable = '0;
    row_wr     = '0;
    slab_wr    = '0;
    cnt_new    = cnt_r;
    st_new     = pick_st_r;
    one_hot    = '0;
    row_wr.addr  = cls_r;
    row_wr.row   = row_r;
    slab_wr.addr = {cls_r, pick_r};
    slab_wr.count = cnt_r;
    slab_wr.bitmap = bm_r;
    if (!op_r) begin
      priority if (zero_r) begin
        res_status = slba_pkg::RES_ZERO;
      end else if (big_r || obj_n == '0) begin
        res_status = slba_pkg::RES_TOO_LARGE;
      end else if (!found_r) begin
        res_status = slba_pkg::RES_NO_SLAB;
      end else if (!scan_found) begin
        res_status = slba_pkg::RES_NO_SLAB;
        row_wr.en  = 1'b1;
        row_wr.row[2*pick_r +: 2] = slba_pkg::SS_FULL;
      end else begin
        cnt_new = cnt_r + CNT_W'(1);
        one_hot[scan_idx] = 1'b1;
        priority if (cnt_new >= obj_n) begin
          st_new = slba_pkg::SS_FULL;
        end else if (cnt_new == CNT_W'(1)) begin
          st_new = slba_pkg::SS_PARTIAL;
        end else if (pick_st_r == slba_pkg::SS_NONE) begin
          st_new = slba_pkg::SS_FREE;
        end else begin
          st_new = pick_st_r;
        end
        res_status = slba_pkg::RES_ALLOC;
        res_class  = cls_r;
        res_slab   = pick_r;
        res_obj    = scan_idx;
        res_usable = slba_pkg::USE_W'(1) << (32'(cls_r) + slba_pkg::MIN_SHIFT);
        row_wr.en  = 1'b1;
        row_wr.row[2*pick_r +: 2] = st_new;
        slab_wr.en     = 1'b1;
        slab_wr.bitmap = bm_r | one_hot;
        slab_wr.count  = cnt_new;
      end
    end else begin
      priority if (ho_r >= obj_n) begin
        res_status = slba_pkg::RES_BAD_FREE;
      end else if (pick_st_r == slba_pkg::SS_NONE || !bm_r[ho_r]) begin
        res_status = slba_pkg::RES_BAD_FREE;
      end else begin
        one_hot[ho_r] = 1'b1;
        cnt_new = (cnt_r != '0) ? cnt_r - CNT_W'(1) : cnt_r;
        priority if (cnt_new == '0) begin
          st_new = slba_pkg::SS_FREE;
        end else if (pick_st_r == slba_pkg::SS_FULL) begin
          st_new = slba_pkg::SS_PARTIAL;
        end else begin
          st_new = pick_st_r;
        end
        res_status = slba_pkg::RES_FREED;
        row_wr.en  = 1'b1;
        row_wr.row[2*pick_r +: 2] = st_new;
        slab_wr.en     = 1'b1;
        slab_wr.bitmap = bm_r & ~one_hot;
        slab_wr.count  = cnt_new;
      end
    end
    // write back only in the cycle the result is registered
    row_wr.en  = row_wr.en && fin_fire;
    slab_wr.en = slab_wr.en && fin_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_ROW;
          end
        end
        S_ROW: state_r <= S_MEM;
        S_MEM: state_r <= S_FIN;
        S_FIN: begin
          if (fin_fire) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_data_r <= {1'b0, res_usable, res_obj, res_slab, res_class, res_status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_fire && res_status != slba_pkg::RES_ALLOC) |->
      (res_class == '0 && res_slab == '0 && res_obj == '0 && res_usable == '0))
    else $error("non-allocate result carries a handle");

  a_obj_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_fire && res_status == slba_pkg::RES_ALLOC) |-> (res_obj < obj_n))
    else $error("allocated object beyond slab capacity");

  a_write_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (slab_wr.en || row_wr.en) |-> (state_r == S_FIN))
    else $error("memory write outside the update cycle");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_ROW) ##1 (state_r == S_MEM))
    else $error("request sequence broken");

  a_result_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire |=> out_tvalid)
    else $error("result lost after update");

endmodule
`default_nettype wire

// File: hw/rtl/slba_status_mem.sv
`default_nettype none
module slba_status_mem (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [slba_pkg::CLS_W-1:0]  rd_addr,
  output logic [slba_pkg::ROW_W-1:0]       rd_row,
  input  wire slba_pkg::row_wr_t           wr
);

  logic [slba_pkg::ROW_W-1:0] mem [slba_pkg::CLASS_N];
  logic [slba_pkg::CLASS_N-1:0] valid_r;
  logic [slba_pkg::ROW_W-1:0] rd_row_r;
  logic rd_v_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.row;
    end
    rd_row_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_v_r <= valid_r[rd_addr];
    end
  end

  // a row never written holds only uncreated slabs
  assign rd_row = rd_v_r ? rd_row_r : '0;

endmodule
`default_nettype wire

// File: hw/rtl/slba_slab_mem.sv
`default_nettype none
module slba_slab_mem (
  input  wire logic                          clk,
  input  wire logic [slba_pkg::SLAB_ID_W-1:0] rd_addr,
  output logic [slba_pkg::OBJ_W-1:0]         rd_bitmap,
  output logic [slba_pkg::CNT_W-1:0]         rd_count,
  input  wire slba_pkg::slab_wr_t            wr
);

  localparam int DEPTH = slba_pkg::CLASS_N * slba_pkg::SLABS;

  logic [slba_pkg::OBJ_W-1:0] bm_mem  [DEPTH];
  logic [slba_pkg::CNT_W-1:0] cnt_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      bm_mem[wr.addr]  <= wr.bitmap;
      cnt_mem[wr.addr] <= wr.count;
    end
    rd_bitmap <= bm_mem[rd_addr];
    rd_count  <= cnt_mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/slba_zero_scan.sv
`default_nettype none
module slba_zero_scan (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [slba_pkg::OBJ_W-1:0]    bitmap,
  input  wire logic [slba_pkg::CNT_W-1:0]    obj_n,
  output logic                               found,
  output logic [slba_pkg::OBJ_IDX_W-1:0]     index
);

  localparam int PAD_W = slba_pkg::CHUNK_N * slba_pkg::CHUNK_W;
  localparam int IN_W  = $clog2(slba_pkg::CHUNK_W);
  localparam int CH_W  = slba_pkg::OBJ_IDX_W - IN_W;

  logic [PAD_W-1:0] masked;
  logic [slba_pkg::CHUNK_N-1:0] any_nxt, any_r;
  logic [IN_W-1:0] idx_nxt [slba_pkg::CHUNK_N];
  logic [IN_W-1:0] idx_r   [slba_pkg::CHUNK_N];

  // objects at or past the slab's capacity read as taken
  always_comb begin
    masked = '1;
    for (int i = 0; i < slba_pkg::OBJ_W; i++) begin
      masked[i] = bitmap[i] | (32'(i) >= 32'(obj_n));
    end
  end

  always_comb begin
    for (int c = 0; c < slba_pkg::CHUNK_N; c++) begin
      any_nxt[c] = 1'b0;
      idx_nxt[c] = '0;
      for (int b = slba_pkg::CHUNK_W - 1; b >= 0; b--) begin
        if (!masked[c*slba_pkg::CHUNK_W + b]) begin
          any_nxt[c] = 1'b1;
          idx_nxt[c] = IN_W'(b);
        end
      end
    end
  end

  // hold the chunk results while the update waits on the output
  always_ff @(posedge clk) begin
    if (en) begin
      any_r <= any_nxt;
      for (int c = 0; c < slba_pkg::CHUNK_N; c++) begin
        idx_r[c] <= idx_nxt[c];
      end
    end
  end

  always_comb begin
    found = |any_r;
    index = '0;
    for (int c = slba_pkg::CHUNK_N - 1; c >= 0; c--) begin
      if (any_r[c]) begin
        index = {CH_W'(c), idx_r[c]};
      end
    end
  end

endmodule
`default_nettype wire
